/* src/scheduled_thermostat_controller_defines.svh */
// Assertion helpers for the thermostat controller.
`ifndef SCHEDULED_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define SCHEDULED_THERMOSTAT_CONTROLLER_DEFINES_SVH

// Checked on every rising clk_i edge outside reset.
`define STC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked outside reset: condition now, consequence next cycle.
`define STC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);

`endif

/* src/stc_pkg.sv */
`default_nettype none

package stc_pkg;

  localparam int REQ_W      = 3;
  localparam int WORD_W     = 16;
  localparam int TEMP_W     = 7;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // sensor LSB is 1/128 degree
  localparam int SENSOR_FRAC_BITS = 7;
  localparam int DEG_W            = WORD_W - SENSOR_FRAC_BITS;

  localparam logic [TEMP_W-1:0] TEMP_MAX  = 7'd99;
  localparam logic [SEC_W-1:0]  SEC_WRAP  = 6'd60;
  localparam logic [MIN_W-1:0]  MIN_WRAP  = 6'd60;
  localparam logic [HOUR_W-1:0] HOUR_WRAP = 5'd24;

  localparam logic [TEMP_W-1:0] TEMP_RST     = 7'd20;
  localparam logic [TEMP_W-1:0] SETPOINT_RST = 7'd20;

  localparam logic [HOUR_W-1:0] SCHED_A_HOUR_RST   = 5'd8;
  localparam logic [MIN_W-1:0]  SCHED_A_MINUTE_RST = 6'd0;
  localparam logic [TEMP_W-1:0] SCHED_A_TARGET_RST = 7'd20;
  localparam logic [HOUR_W-1:0] SCHED_B_HOUR_RST   = 5'd20;
  localparam logic [MIN_W-1:0]  SCHED_B_MINUTE_RST = 6'd0;
  localparam logic [TEMP_W-1:0] SCHED_B_TARGET_RST = 7'd15;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_BTN_DOWN = 3'd1,
    REQ_BTN_UP   = 3'd2,
    REQ_SENSOR   = 3'd3,
    REQ_REMOTE   = 3'd4,
    REQ_SET_TIME = 3'd5
  } stc_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHED_A_HOUR   = 3'd0,
    CFG_SCHED_A_MINUTE = 3'd1,
    CFG_SCHED_A_TARGET = 3'd2,
    CFG_SCHED_B_HOUR   = 3'd3,
    CFG_SCHED_B_MINUTE = 3'd4,
    CFG_SCHED_B_TARGET = 3'd5
  } stc_cfg_idx_e;

  typedef struct packed {
    logic [HOUR_W-1:0] a_hour;
    logic [MIN_W-1:0]  a_minute;
    logic [TEMP_W-1:0] a_target;
    logic [HOUR_W-1:0] b_hour;
    logic [MIN_W-1:0]  b_minute;
    logic [TEMP_W-1:0] b_target;
  } stc_cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [WORD_W-1:0]        sensor_word;
    logic                     sensor_ok;
    logic signed [WORD_W-1:0] requested_setpoint;
    logic [HOUR_W-1:0]        load_hour;
    logic [MIN_W-1:0]         load_minute;
    logic [SEC_W-1:0]         load_second;
  } stc_req_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [TEMP_W-1:0] setpoint;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              down_pend;
    logic              up_pend;
  } stc_state_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_now;
    logic [TEMP_W-1:0] setpoint_now;
    logic              heat_on;
    logic [HOUR_W-1:0] clock_hour;
    logic [MIN_W-1:0]  clock_minute;
    logic [SEC_W-1:0]  clock_second;
    logic              ack;
    logic              schedule_applied;
  } stc_result_t;

endpackage

`default_nettype wire

/* src/stc_if.sv */
`default_nettype none

interface stc_req_if;
  logic                              valid;
  logic                              ready;
  logic [stc_pkg::REQ_W-1:0]         req_type;
  logic [stc_pkg::WORD_W-1:0]        sensor_word;
  logic                              sensor_ok;
  logic signed [stc_pkg::WORD_W-1:0] requested_setpoint;
  logic [stc_pkg::HOUR_W-1:0]        load_hour;
  logic [stc_pkg::MIN_W-1:0]         load_minute;
  logic [stc_pkg::SEC_W-1:0]         load_second;

  modport source (
    output valid, req_type, sensor_word, sensor_ok, requested_setpoint,
           load_hour, load_minute, load_second,
    input  ready
  );
  modport sink (
    input  valid, req_type, sensor_word, sensor_ok, requested_setpoint,
           load_hour, load_minute, load_second,
    output ready
  );
endinterface

interface stc_res_if;
  logic                       valid;
  logic                       ready;
  logic [stc_pkg::TEMP_W-1:0] temp_now;
  logic [stc_pkg::TEMP_W-1:0] setpoint_now;
  logic                       heat_on;
  logic [stc_pkg::HOUR_W-1:0] clock_hour;
  logic [stc_pkg::MIN_W-1:0]  clock_minute;
  logic [stc_pkg::SEC_W-1:0]  clock_second;
  logic                       ack;
  logic                       schedule_applied;

  modport source (
    output valid, temp_now, setpoint_now, heat_on, clock_hour, clock_minute,
           clock_second, ack, schedule_applied,
    input  ready
  );
  modport sink (
    input  valid, temp_now, setpoint_now, heat_on, clock_hour, clock_minute,
           clock_second, ack, schedule_applied,
    output ready
  );
endinterface

`default_nettype wire

/* src/stc_cfg_regs.sv */
`default_nettype none

module stc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output stc_pkg::stc_cfg_t              cfg_o
);
  import stc_pkg::*;

  stc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (stc_cfg_idx_e'(cfg_idx_i))
        CFG_SCHED_A_HOUR:   cfg_d.a_hour   = cfg_wdata_i[HOUR_W-1:0];
        CFG_SCHED_A_MINUTE: cfg_d.a_minute = cfg_wdata_i[MIN_W-1:0];
        CFG_SCHED_A_TARGET: cfg_d.a_target = cfg_wdata_i[TEMP_W-1:0];
        CFG_SCHED_B_HOUR:   cfg_d.b_hour   = cfg_wdata_i[HOUR_W-1:0];
        CFG_SCHED_B_MINUTE: cfg_d.b_minute = cfg_wdata_i[MIN_W-1:0];
        CFG_SCHED_B_TARGET: cfg_d.b_target = cfg_wdata_i[TEMP_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_hour   <= SCHED_A_HOUR_RST;
      cfg_q.a_minute <= SCHED_A_MINUTE_RST;
      cfg_q.a_target <= SCHED_A_TARGET_RST;
      cfg_q.b_hour   <= SCHED_B_HOUR_RST;
      cfg_q.b_minute <= SCHED_B_MINUTE_RST;
      cfg_q.b_target <= SCHED_B_TARGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/stc_step.sv */
`default_nettype none

module stc_step (
  input  stc_pkg::stc_cfg_t    cfg_i,
  input  stc_pkg::stc_state_t  state_i,
  input  stc_pkg::stc_req_t    req_i,
  output stc_pkg::stc_state_t  state_o,
  output stc_pkg::stc_result_t result_o
);
  import stc_pkg::*;

  logic [SEC_W-1:0]  sec_inc;
  logic [MIN_W-1:0]  min_inc;
  logic [HOUR_W-1:0] hour_inc;
  logic [SEC_W-1:0]  tick_sec;
  logic [MIN_W-1:0]  tick_min;
  logic [HOUR_W-1:0] tick_hour;
  logic              sec_wrap;
  logic              min_wrap;
  logic              match_a;
  logic              match_b;
  logic [TEMP_W-1:0] target_a;
  logic [TEMP_W-1:0] target_b;
  logic signed [DEG_W-1:0] deg;
  logic [TEMP_W-1:0] sensor_temp;
  logic              remote_ok;
  logic              ack;
  logic              applied;
  stc_state_t        s;

  // hh:mm:ss rollover
  always_comb begin
    sec_inc  = state_i.second + SEC_W'(1);
    min_inc  = state_i.minute + MIN_W'(1);
    hour_inc = state_i.hour + HOUR_W'(1);
    sec_wrap = (sec_inc >= SEC_WRAP);
    min_wrap = (min_inc >= MIN_WRAP);
    tick_sec  = sec_wrap ? '0 : sec_inc;
    tick_min  = state_i.minute;
    tick_hour = state_i.hour;
    if (sec_wrap) begin
      tick_min = min_wrap ? '0 : min_inc;
      if (min_wrap) begin
        tick_hour = (hour_inc >= HOUR_WRAP) ? '0 : hour_inc;
      end
    end
  end

  assign match_a  = (tick_sec == '0) && (tick_hour == cfg_i.a_hour) &&
                    (tick_min == cfg_i.a_minute);
  assign match_b  = (tick_sec == '0) && (tick_hour == cfg_i.b_hour) &&
                    (tick_min == cfg_i.b_minute);
  assign target_a = (cfg_i.a_target > TEMP_MAX) ? TEMP_MAX : cfg_i.a_target;
  assign target_b = (cfg_i.b_target > TEMP_MAX) ? TEMP_MAX : cfg_i.b_target;

  // floor(word / 128) as an arithmetic shift, then clamp to 0..99
  assign deg = signed'(req_i.sensor_word[WORD_W-1:SENSOR_FRAC_BITS]);
  always_comb begin
    if (!req_i.sensor_ok || deg[DEG_W-1]) begin
      sensor_temp = '0;
    end else if (deg[DEG_W-2:0] > (DEG_W-1)'(TEMP_MAX)) begin
      sensor_temp = TEMP_MAX;
    end else begin
      sensor_temp = deg[TEMP_W-1:0];
    end
  end

  assign remote_ok = !req_i.requested_setpoint[WORD_W-1] &&
                     (req_i.requested_setpoint <= $signed(WORD_W'(TEMP_MAX)));

  always_comb begin
    s       = state_i;
    ack     = 1'b0;
    applied = 1'b0;
    case (stc_req_e'(req_i.req_type))
      REQ_TICK: begin
        s.second = tick_sec;
        s.minute = tick_min;
        s.hour   = tick_hour;
        if (match_b) begin
          s.setpoint = target_b;
        end else if (match_a) begin
          s.setpoint = target_a;
        end
        applied = match_a || match_b;
      end
      REQ_BTN_DOWN: s.down_pend = 1'b1;
      REQ_BTN_UP:   s.up_pend   = 1'b1;
      REQ_SENSOR:   s.temp      = sensor_temp;
      REQ_REMOTE: begin
        if (remote_ok) begin
          s.setpoint = req_i.requested_setpoint[TEMP_W-1:0];
          ack        = 1'b1;
        end
      end
      REQ_SET_TIME: begin
        s.hour   = (req_i.load_hour >= HOUR_WRAP) ? HOUR_WRAP - HOUR_W'(1)
                                                  : req_i.load_hour;
        s.minute = (req_i.load_minute >= MIN_WRAP) ? MIN_WRAP - MIN_W'(1)
                                                   : req_i.load_minute;
        s.second = (req_i.load_second >= SEC_WRAP) ? SEC_WRAP - SEC_W'(1)
                                                   : req_i.load_second;
      end
      default: ;
    endcase

    // pending buttons resolve after every transaction, down before up
    if (s.down_pend && (s.setpoint != '0)) begin
      s.setpoint  = s.setpoint - TEMP_W'(1);
      s.down_pend = 1'b0;
    end
    if (s.up_pend && (s.setpoint < TEMP_MAX)) begin
      s.setpoint = s.setpoint + TEMP_W'(1);
      s.up_pend  = 1'b0;
    end
  end

  assign state_o = s;

  always_comb begin
    result_o.temp_now         = s.temp;
    result_o.setpoint_now     = s.setpoint;
    result_o.heat_on          = (s.temp < s.setpoint);
    result_o.clock_hour       = s.hour;
    result_o.clock_minute     = s.minute;
    result_o.clock_second     = s.second;
    result_o.ack              = ack;
    result_o.schedule_applied = applied;
  end

endmodule

`default_nettype wire

/* src/scheduled_thermostat_controller.sv */
// Requests are held in a request register; when the result register is free or
// being taken, the combinational state update writes the result register.
// Throughput: one request per cycle while results are taken without back-pressure;
// the combinational state update lies between the request and result registers.
// Reset (async, active low): schedule registers take their defaults, the
// clock reads 00:00:00, temperature and setpoint 20, no pending buttons.
`default_nettype none
`include "scheduled_thermostat_controller_defines.svh"

module scheduled_thermostat_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  stc_req_if.sink                        req_i,
  stc_res_if.source                      res_o
);
  import stc_pkg::*;

  stc_cfg_t    cfg;
  stc_req_t    in_q;
  logic        in_valid_q;
  stc_state_t  state_q;
  stc_state_t  state_d;
  stc_result_t res_q;
  stc_result_t res_d;
  logic        res_valid_q;
  logic        res_load;
  logic        in_adv;
  logic        in_take;
  logic        state_in_range;
  logic        sched_at_zero;

  stc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  stc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .req_i    (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign res_load    = !res_valid_q || res_o.ready;
  assign in_adv      = in_valid_q && res_load;
  assign req_i.ready = !in_valid_q || res_load;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (in_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type           <= req_i.req_type;
      in_q.sensor_word        <= req_i.sensor_word;
      in_q.sensor_ok          <= req_i.sensor_ok;
      in_q.requested_setpoint <= req_i.requested_setpoint;
      in_q.load_hour          <= req_i.load_hour;
      in_q.load_minute        <= req_i.load_minute;
      in_q.load_second        <= req_i.load_second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.temp      <= TEMP_RST;
      state_q.setpoint  <= SETPOINT_RST;
      state_q.hour      <= '0;
      state_q.minute    <= '0;
      state_q.second    <= '0;
      state_q.down_pend <= 1'b0;
      state_q.up_pend   <= 1'b0;
    end else if (in_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= in_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.temp_now         = res_q.temp_now;
  assign res_o.setpoint_now     = res_q.setpoint_now;
  assign res_o.heat_on          = res_q.heat_on;
  assign res_o.clock_hour       = res_q.clock_hour;
  assign res_o.clock_minute     = res_q.clock_minute;
  assign res_o.clock_second     = res_q.clock_second;
  assign res_o.ack              = res_q.ack;
  assign res_o.schedule_applied = res_q.schedule_applied;

  assign state_in_range = (state_q.setpoint <= TEMP_MAX) && (state_q.temp <= TEMP_MAX) &&
                          (state_q.hour < HOUR_WRAP) && (state_q.minute < MIN_WRAP) &&
                          (state_q.second < SEC_WRAP);
  assign sched_at_zero  = !res_valid_q || !res_q.schedule_applied ||
                          (res_q.clock_second == '0);

  `STC_ASSERT(a_state_range, state_in_range, "state out of range")
  `STC_ASSERT_NEXT(a_state_hold, !in_adv, $stable(state_q), "state moved without a transaction")
  `STC_ASSERT(a_sched_on_zero, sched_at_zero, "schedule applied off second zero")
  `STC_ASSERT(a_ready_stall, req_i.ready || (in_valid_q && res_valid_q), "stall with free stage")

endmodule

`default_nettype wire
